@@ rtl/hbc_pkg.sv @@
// Package for the uniform-bin histogram counter.
// Holds the default sizes, command and register codes, and the control and
// status bundles passed between the controller and the datapath.
package hbc_pkg;

  localparam int MAX_BINS_DEF    = 64;
  localparam int SAMPLE_BITS_DEF = 16;
  localparam int COUNT_BITS_DEF  = 32;

  localparam int BINS_W      = 7;
  localparam int INDEX_W     = 6;
  localparam int OUT_W       = 32;
  localparam int CMD_W       = 2;
  localparam int CFG_INDEX_W = 2;

  localparam logic [BINS_W-1:0] MIN_BINS   = BINS_W'(2);
  localparam logic [BINS_W-1:0] BINS_RESET = BINS_W'(64);

  localparam logic [CMD_W-1:0] CMD_ADD   = 2'd0;
  localparam logic [CMD_W-1:0] CMD_READ  = 2'd1;
  localparam logic [CMD_W-1:0] CMD_CLEAR = 2'd2;

  localparam logic [CFG_INDEX_W-1:0] REG_LOWER = 2'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_UPPER = 2'd1;
  localparam logic [CFG_INDEX_W-1:0] REG_BINS  = 2'd2;

  typedef struct packed {
    logic load;
    logic prep;
    logic div_step;
    logic rd_bin;
    logic upd;
    logic pend_rd;
    logic clr_step;
    logic clr_ack;
    logic out_load;
  } hbc_cmd_t;

  typedef struct packed {
    logic [CMD_W-1:0] item_cmd;
    logic             add_ok;
    logic             read_ok;
    logic             div_last;
    logic             clr_last;
  } hbc_status_t;

endpackage

@@ rtl/hbc_ram.sv @@
// Generic single-port-write, single-port-read RAM with registered read data.
// Depends on nothing but its parameters.
module hbc_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

@@ rtl/hbc_datapath.sv @@
// Datapath of the histogram counter: configuration registers, bin index
// multiplier and bit-serial divider, count memory and result registers.
// Depends on hbc_pkg and hbc_ram.
module hbc_datapath import hbc_pkg::*; #(
  parameter int MAX_BINS    = MAX_BINS_DEF,
  parameter int SAMPLE_BITS = SAMPLE_BITS_DEF,
  parameter int COUNT_BITS  = COUNT_BITS_DEF
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic [CMD_W-1:0]       cmd,
  input  logic [SAMPLE_BITS-1:0] sample_value,
  input  logic [INDEX_W-1:0]     bin_index,
  input  logic                   cfg_valid,
  input  logic [CFG_INDEX_W-1:0] cfg_index,
  input  logic [SAMPLE_BITS-1:0] cfg_data,
  input  hbc_cmd_t               ctrl,
  output hbc_status_t            status,
  output logic                   accepted,
  output logic [OUT_W-1:0]       bin_count,
  output logic [OUT_W-1:0]       total_samples
);

  localparam int AW = $clog2(MAX_BINS);
  localparam int QW = BINS_W;
  localparam int PW = SAMPLE_BITS + BINS_W;
  localparam int SW = $clog2(QW);

  logic signed [SAMPLE_BITS-1:0] lower_bound;
  logic signed [SAMPLE_BITS-1:0] upper_bound;
  logic [BINS_W-1:0]             bins_reg;

  logic [CMD_W-1:0]              item_cmd;
  logic signed [SAMPLE_BITS-1:0] item_sample;
  logic [INDEX_W-1:0]            item_index;

  logic [SAMPLE_BITS-1:0] rem;
  logic [QW-1:0]          dlow;
  logic [QW-1:0]          quot;
  logic [SAMPLE_BITS-1:0] range_reg;
  logic [SW-1:0]          step;

  logic [AW-1:0]         bin_addr;
  logic [AW-1:0]         clr_addr;
  logic [COUNT_BITS-1:0] total;
  logic                  pend_acc;
  logic [COUNT_BITS-1:0] pend_cnt;

  logic [BINS_W-1:0]      nb;
  logic [SAMPLE_BITS-1:0] off_w;
  logic [SAMPLE_BITS-1:0] range_w;
  logic [PW-1:0]          product;
  logic [SAMPLE_BITS:0]   trial;
  logic                   trial_ge;
  logic [QW-1:0]          q_clamped;
  logic [AW-1:0]          bin_sel;
  logic                   ram_we;
  logic [AW-1:0]          ram_waddr;
  logic [COUNT_BITS-1:0]  ram_wdata;
  logic                   ram_re;
  logic [AW-1:0]          ram_raddr;
  logic [COUNT_BITS-1:0]  rdata;
  logic [COUNT_BITS-1:0]  new_count;
  logic [COUNT_BITS-1:0]  total_inc;

  always_comb begin
    if (32'(bins_reg) > 32'(MAX_BINS)) begin
      nb = BINS_W'(MAX_BINS);
    end else begin
      nb = bins_reg;
    end
  end

  assign off_w   = item_sample - lower_bound;
  assign range_w = upper_bound - lower_bound;
  assign product = PW'(off_w) * PW'(nb);

  assign status.item_cmd = item_cmd;
  assign status.add_ok   = (lower_bound < upper_bound) && (nb >= MIN_BINS)
                         && (item_sample >= lower_bound) && (item_sample <= upper_bound);
  assign status.read_ok  = (nb >= MIN_BINS) && (BINS_W'(item_index) < nb);
  assign status.div_last = (step == SW'(QW - 1));
  assign status.clr_last = (clr_addr == AW'(MAX_BINS - 1));

  assign trial    = {rem, dlow[QW-1]};
  assign trial_ge = (trial >= {1'b0, range_reg});

  assign q_clamped = (quot >= nb) ? (nb - 1'b1) : quot;
  assign bin_sel   = AW'(q_clamped);

  assign new_count = (rdata == '1) ? rdata : rdata + 1'b1;
  assign total_inc = (total == '1) ? total : total + 1'b1;

  assign ram_we    = ctrl.clr_step | ctrl.upd;
  assign ram_waddr = ctrl.clr_step ? clr_addr : bin_addr;
  assign ram_wdata = ctrl.clr_step ? '0 : new_count;
  assign ram_re    = ctrl.prep | ctrl.rd_bin;
  assign ram_raddr = ctrl.rd_bin ? bin_sel : AW'(item_index);

  hbc_ram #(
    .WIDTH(COUNT_BITS),
    .DEPTH(MAX_BINS)
  ) u_count_ram (
    .clk  (clk),
    .we   (ram_we),
    .waddr(ram_waddr),
    .wdata(ram_wdata),
    .re   (ram_re),
    .raddr(ram_raddr),
    .rdata(rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      lower_bound <= {1'b1, {(SAMPLE_BITS-1){1'b0}}};
      upper_bound <= {1'b0, {(SAMPLE_BITS-1){1'b1}}};
      bins_reg    <= BINS_RESET;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        REG_LOWER: lower_bound <= cfg_data;
        REG_UPPER: upper_bound <= cfg_data;
        REG_BINS:  bins_reg    <= cfg_data[BINS_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      clr_addr <= '0;
    end else if (ctrl.clr_step) begin
      clr_addr <= status.clr_last ? '0 : clr_addr + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.load) begin
      item_cmd    <= cmd;
      item_sample <= sample_value;
      item_index  <= bin_index;
      pend_acc    <= 1'b0;
      pend_cnt    <= '0;
    end
    if (ctrl.prep) begin
      rem       <= product[PW-1:QW];
      dlow      <= product[QW-1:0];
      quot      <= '0;
      range_reg <= range_w;
      step      <= '0;
    end
    if (ctrl.div_step) begin
      rem  <= trial_ge ? SAMPLE_BITS'(trial - {1'b0, range_reg}) : trial[SAMPLE_BITS-1:0];
      dlow <= {dlow[QW-2:0], 1'b0};
      quot <= {quot[QW-2:0], trial_ge};
      step <= step + 1'b1;
    end
    if (ctrl.rd_bin) begin
      bin_addr <= bin_sel;
    end
    if (ctrl.upd) begin
      total    <= total_inc;
      pend_acc <= 1'b1;
      pend_cnt <= new_count;
    end
    if (ctrl.pend_rd) begin
      pend_acc <= 1'b1;
      pend_cnt <= rdata;
    end
    if (ctrl.clr_step) begin
      total <= '0;
    end
    if (ctrl.clr_ack) begin
      pend_acc <= 1'b1;
    end
    if (ctrl.out_load) begin
      accepted      <= pend_acc;
      bin_count     <= OUT_W'(pend_cnt);
      total_samples <= OUT_W'(total);
    end
  end

endmodule

@@ rtl/hbc_ctrl.sv @@
// Controller of the histogram counter: sequences each item through the
// datapath and holds the handshake state of both channels.
// Depends on hbc_pkg.
module hbc_ctrl import hbc_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  output logic        out_valid,
  input  logic        out_ready,
  input  hbc_status_t status,
  output hbc_cmd_t    ctrl
);

  typedef enum logic [3:0] {
    S_INIT,
    S_IDLE,
    S_PREP,
    S_DIV,
    S_RBIN,
    S_UPD,
    S_RDATA,
    S_CLEAR,
    S_FIN
  } state_t;

  state_t state;
  logic   fin_fire;

  assign in_ready = (state == S_IDLE);
  assign fin_fire = (state == S_FIN) && (!out_valid || out_ready);

  always_comb begin
    ctrl          = '0;
    ctrl.load     = (state == S_IDLE) && in_valid;
    ctrl.prep     = (state == S_PREP);
    ctrl.div_step = (state == S_DIV);
    ctrl.rd_bin   = (state == S_RBIN);
    ctrl.upd      = (state == S_UPD);
    ctrl.pend_rd  = (state == S_RDATA);
    ctrl.clr_step = (state == S_INIT) || (state == S_CLEAR);
    ctrl.clr_ack  = (state == S_CLEAR) && status.clr_last;
    ctrl.out_load = fin_fire;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_INIT;
      out_valid <= 1'b0;
    end else begin
      if (fin_fire) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        S_INIT: begin
          if (status.clr_last) begin
            state <= S_IDLE;
          end
        end
        S_IDLE: begin
          if (in_valid) begin
            state <= S_PREP;
          end
        end
        S_PREP: begin
          priority if ((status.item_cmd == CMD_ADD) && status.add_ok) begin
            state <= S_DIV;
          end else if ((status.item_cmd == CMD_READ) && status.read_ok) begin
            state <= S_RDATA;
          end else if (status.item_cmd == CMD_CLEAR) begin
            state <= S_CLEAR;
          end else begin
            state <= S_FIN;
          end
        end
        S_DIV: begin
          if (status.div_last) begin
            state <= S_RBIN;
          end
        end
        S_RBIN:  state <= S_UPD;
        S_UPD:   state <= S_FIN;
        S_RDATA: state <= S_FIN;
        S_CLEAR: begin
          if (status.clr_last) begin
            state <= S_FIN;
          end
        end
        S_FIN: begin
          if (fin_fire) begin
            state <= S_IDLE;
          end
        end
        default: state <= S_INIT;
      endcase
    end
  end

endmodule

@@ rtl/histogram_binning_counter_top.sv @@
// Uniform-bin histogram counter, top level. An add goes through prep, the
// one-bit-a-cycle divider, bin read and update; a read through prep and data
// read; a clear through prep and a clear of one memory row a cycle; a rejected
// or unused item through prep alone. The next item is taken in the cycle after
// the result is registered. After reset a clearing pass zeroes the count
// memory and holds in_ready low; configuration writes are taken throughout.
module histogram_binning_counter_top import hbc_pkg::*; #(
  parameter int MAX_BINS    = MAX_BINS_DEF,
  parameter int SAMPLE_BITS = SAMPLE_BITS_DEF,
  parameter int COUNT_BITS  = COUNT_BITS_DEF
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   in_valid,
  output logic                   in_ready,
  input  logic [CMD_W-1:0]       cmd,
  input  logic [SAMPLE_BITS-1:0] sample_value,
  input  logic [INDEX_W-1:0]     bin_index,
  output logic                   out_valid,
  input  logic                   out_ready,
  output logic                   accepted,
  output logic [OUT_W-1:0]       bin_count,
  output logic [OUT_W-1:0]       total_samples,
  input  logic                   cfg_valid,
  output logic                   cfg_ready,
  input  logic [CFG_INDEX_W-1:0] cfg_index,
  input  logic [SAMPLE_BITS-1:0] cfg_data
);

  hbc_cmd_t    ctrl;
  hbc_status_t status;

  assign cfg_ready = 1'b1;

  hbc_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .status   (status),
    .ctrl     (ctrl)
  );

  hbc_datapath #(
    .MAX_BINS   (MAX_BINS),
    .SAMPLE_BITS(SAMPLE_BITS),
    .COUNT_BITS (COUNT_BITS)
  ) u_datapath (
    .clk          (clk),
    .rst          (rst),
    .cmd          (cmd),
    .sample_value (sample_value),
    .bin_index    (bin_index),
    .cfg_valid    (cfg_valid),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .ctrl         (ctrl),
    .status       (status),
    .accepted     (accepted),
    .bin_count    (bin_count),
    .total_samples(total_samples)
  );

endmodule

@@ dv/testbench.sv @@
`timescale 1ns / 1ps
// Self-checking testbench for histogram_binning_counter_top: directed and random items,
// register writes between phases, and an in-line prediction of every result.
// Depends on hbc_pkg and the top-level RTL.
module testbench;
  import hbc_pkg::*;

  localparam logic [CMD_W-1:0]       CMD_UNUSED = 2'd3;
  localparam logic [CFG_INDEX_W-1:0] REG_NONE   = 2'd3;
  localparam int SW          = SAMPLE_BITS_DEF;
  localparam int NPHASES     = 17;
  localparam int PHASE_ITEMS = 120;

  typedef struct {
    logic [CMD_W-1:0]     op;
    logic signed [SW-1:0] value;
    logic [INDEX_W-1:0]   slot;
  } hist_item_t;

  typedef struct {
    logic             acc;
    logic [OUT_W-1:0] count;
    logic [OUT_W-1:0] total;
  } hist_result_t;

  logic                   clk = 1'b0;
  logic                   rst = 1'b1;
  logic                   in_valid = 1'b0;
  logic                   in_ready;
  logic [CMD_W-1:0]       cmd = CMD_ADD;
  logic [SW-1:0]          sample_value = '0;
  logic [INDEX_W-1:0]     bin_index = '0;
  logic                   out_valid;
  logic                   out_ready = 1'b0;
  logic                   accepted;
  logic [OUT_W-1:0]       bin_count;
  logic [OUT_W-1:0]       total_samples;
  logic                   cfg_valid = 1'b0;
  logic                   cfg_ready;
  logic [CFG_INDEX_W-1:0] cfg_index = REG_LOWER;
  logic [SW-1:0]          cfg_data = '0;

  // Predictor copy of the block's registers and counts.
  logic signed [SW-1:0] lower_reg = 16'sh8000;
  logic signed [SW-1:0] upper_reg = 16'sh7FFF;
  logic [BINS_W-1:0]    bins_reg  = BINS_RESET;
  logic [OUT_W-1:0]     bin_totals [MAX_BINS_DEF];
  logic [OUT_W-1:0]     sample_sum = '0;

  hist_item_t   pending_items[$];
  hist_result_t expected_results[$];
  logic         item_taken = 1'b0;
  logic         no_idle = 1'b0;
  int           send_gap = 0;
  int           stall_left = 0;
  int           mismatches = 0;

  histogram_binning_counter_top dut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_ready(in_ready),
    .cmd(cmd), .sample_value(sample_value), .bin_index(bin_index),
    .out_valid(out_valid), .out_ready(out_ready),
    .accepted(accepted), .bin_count(bin_count), .total_samples(total_samples),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
    .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  initial begin
    forever #6 clk = ~clk;
  end

  function automatic int idle_len();
    int p;
    p = $urandom_range(0, 99);
    if (p < 55) return 0;
    if (p < 85) return $urandom_range(1, 3);
    if (p < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  function automatic int bins_effective();
    return (int'(bins_reg) > MAX_BINS_DEF) ? MAX_BINS_DEF : int'(bins_reg);
  endfunction

  function automatic hist_result_t bin_and_count(hist_item_t it);
    hist_result_t r;
    int           nb;
    longint       lo, hi, off, span, b;
    r.acc   = 1'b0;
    r.count = '0;
    nb = bins_effective();
    lo = longint'(lower_reg);
    hi = longint'(upper_reg);
    case (it.op)
      CMD_ADD: begin
        if (lo < hi && nb >= int'(MIN_BINS) &&
            longint'(it.value) >= lo && longint'(it.value) <= hi) begin
          off  = longint'(it.value) - lo;
          span = hi - lo;
          b    = (off * nb) / span;
          if (b >= nb) b = nb - 1;
          if (bin_totals[b] != '1) bin_totals[b] = bin_totals[b] + 1'b1;
          if (sample_sum != '1) sample_sum = sample_sum + 1'b1;
          r.acc   = 1'b1;
          r.count = bin_totals[b];
        end
      end
      CMD_READ: begin
        if (nb >= int'(MIN_BINS) && int'(it.slot) < nb) begin
          r.acc   = 1'b1;
          r.count = bin_totals[it.slot];
        end
      end
      CMD_CLEAR: begin
        foreach (bin_totals[i]) bin_totals[i] = '0;
        sample_sum = '0;
        r.acc      = 1'b1;
      end
      default: begin
      end
    endcase
    r.total = sample_sum;
    return r;
  endfunction

  function automatic hist_item_t random_item();
    hist_item_t it;
    int         p, nb, lo, hi;
    nb = bins_effective();
    lo = int'(lower_reg);
    hi = int'(upper_reg);
    it.op    = CMD_ADD;
    it.value = SW'($urandom);
    it.slot  = INDEX_W'($urandom);
    p = $urandom_range(0, 99);
    if (p < 2) begin
      it.op = CMD_CLEAR;
    end else if (p < 4) begin
      it.op = CMD_UNUSED;
    end else if (p < 30) begin
      it.op = CMD_READ;
      if (nb > 0 && $urandom_range(0, 3) != 0) it.slot = INDEX_W'($urandom_range(0, nb - 1));
    end else begin
      p = $urandom_range(0, 9);
      case (p)
        0: it.value = SW'(lo);
        1: it.value = SW'(hi);
        2: it.value = SW'(lo - 1);
        3: it.value = SW'(hi + 1);
        4: begin
        end
        default: begin
          if (lo < hi) it.value = SW'(lo + int'($urandom_range(0, hi - lo)));
        end
      endcase
    end
    return it;
  endfunction

  task automatic push_item(logic [CMD_W-1:0] op, int value, int slot);
    hist_item_t it;
    it.op    = op;
    it.value = SW'(value);
    it.slot  = INDEX_W'(slot);
    pending_items.push_back(it);
  endtask

  task automatic write_reg(logic [CFG_INDEX_W-1:0] idx, logic [SW-1:0] data);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    case (idx)
      REG_LOWER: lower_reg = data;
      REG_UPPER: upper_reg = data;
      REG_BINS:  bins_reg  = data[BINS_W-1:0];
      default: begin
      end
    endcase
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  // Waits until nothing is in flight, then idles long enough for a full clear to finish.
  task automatic drain();
    do @(posedge clk);
    while (pending_items.size() != 0 || in_valid || expected_results.size() != 0);
    repeat (MAX_BINS_DEF + 4) @(posedge clk);
  endtask

  always @(negedge clk) begin
    hist_item_t it;
    logic       next_valid;
    next_valid = in_valid && !item_taken;
    item_taken = 1'b0;
    if (!rst && !next_valid) begin
      if (send_gap > 0) begin
        send_gap--;
      end else if (pending_items.size() > 0) begin
        it = pending_items.pop_front();
        cmd          <= it.op;
        sample_value <= it.value;
        bin_index    <= it.slot;
        next_valid = 1'b1;
        send_gap   = no_idle ? 0 : idle_len();
      end
    end
    in_valid <= next_valid;
  end

  always @(negedge clk) begin
    if (stall_left > 0) begin
      stall_left--;
      out_ready <= 1'b0;
    end else begin
      out_ready <= 1'b1;
      if (!no_idle && $urandom_range(0, 3) == 0) stall_left = idle_len();
    end
  end

  always @(posedge clk) begin
    hist_item_t   it;
    hist_result_t want;
    if (!rst) begin
      if (out_valid && out_ready) begin
        if (expected_results.size() == 0) begin
          $display("%0t: unexpected result: expected none, actual %0d %0d %0d",
                   $time, accepted, bin_count, total_samples);
          mismatches++;
        end else begin
          want = expected_results.pop_front();
          if (accepted !== want.acc) begin
            $display("%0t: accepted: expected %0d, actual %0d", $time, want.acc, accepted);
            mismatches++;
          end
          if (bin_count !== want.count) begin
            $display("%0t: bin_count: expected %0d, actual %0d", $time, want.count, bin_count);
            mismatches++;
          end
          if (total_samples !== want.total) begin
            $display("%0t: total_samples: expected %0d, actual %0d",
                     $time, want.total, total_samples);
            mismatches++;
          end
        end
      end
      if (in_valid && in_ready) begin
        it.op    = cmd;
        it.value = sample_value;
        it.slot  = bin_index;
        expected_results.push_back(bin_and_count(it));
        item_taken = 1'b1;
      end
    end
  end

  initial begin
    #25_000_000;
    $display("FAILED: results differ");
    $finish;
  end

  initial begin
    int phase_lo   [NPHASES];
    int phase_hi   [NPHASES];
    int phase_bins [NPHASES];
    int a, b;
    logic [SW-1:0] bins_data;
    phase_lo   = '{-32768, -32768, 32766, -100, 5, 1000, -50, -50, -50,
                   -32768, -1, 0, 0, 0, 0, 0, -32768};
    phase_hi   = '{32767, -32767, 32767, 100, 5, -1000, 50, 50, 50,
                   32767, 0, 63, 0, 0, 0, 0, 32767};
    phase_bins = '{64, 2, 64, 7, 10, 3, 1, 0, 100, 127, 64, 64,
                   0, 0, 0, 0, 64};
    foreach (bin_totals[i]) bin_totals[i] = '0;
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    push_item(CMD_ADD, -32768, 0);
    push_item(CMD_ADD, 32767, 63);
    push_item(CMD_ADD, 0, 0);
    push_item(CMD_ADD, -1, 0);
    push_item(CMD_ADD, 1, 0);
    push_item(CMD_READ, 0, 0);
    push_item(CMD_READ, 0, 63);
    push_item(CMD_READ, 0, 32);
    push_item(CMD_READ, 0, 31);
    push_item(CMD_UNUSED, 16'h5555, 42);
    push_item(CMD_CLEAR, 0, 0);
    push_item(CMD_READ, 0, 32);
    push_item(CMD_ADD, 32767, 0);
    push_item(CMD_READ, 0, 63);
    push_item(CMD_ADD, -32768, 0);
    push_item(CMD_UNUSED, 16'hAAAA, 21);
    repeat (PHASE_ITEMS) pending_items.push_back(random_item());
    drain();

    for (int ph = 1; ph < NPHASES; ph++) begin
      if (ph >= 12 && ph <= 15) begin
        a = $urandom_range(0, 65535) - 32768;
        b = $urandom_range(0, 65535) - 32768;
        phase_lo[ph]   = (a < b) ? a : b;
        phase_hi[ph]   = (a < b) ? b : a;
        phase_bins[ph] = (ph == 15) ? $urandom_range(0, 127) : $urandom_range(2, 64);
      end
      if (ph == 3) write_reg(REG_NONE, SW'($urandom));
      bins_data = SW'($urandom);
      bins_data[BINS_W-1:0] = BINS_W'(phase_bins[ph]);
      write_reg(REG_LOWER, SW'(phase_lo[ph]));
      write_reg(REG_UPPER, SW'(phase_hi[ph]));
      write_reg(REG_BINS, bins_data);
      no_idle = ($urandom_range(0, 3) == 0);
      repeat (PHASE_ITEMS) pending_items.push_back(random_item());
      drain();
    end

    if (mismatches == 0 && expected_results.size() == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

endmodule
